/* rtl/crmf_pkg.sv */
package crmf_pkg;

    typedef enum logic [2:0] {
        MODE_INIT       = 3'd0,
        MODE_SELF_TEST  = 3'd1,
        MODE_IDLE       = 3'd2,
        MODE_ARMED      = 3'd3,
        MODE_RECORDING  = 3'd4,
        MODE_POST_CRASH = 3'd5,
        MODE_FAULT      = 3'd6
    } mode_t;

    localparam logic [1:0] ACT_EVENT = 2'd0;
    localparam logic [1:0] ACT_TICK  = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;

    localparam logic [3:0] EVT_INIT_COMPLETE   = 4'd0;
    localparam logic [3:0] EVT_PASS            = 4'd1;
    localparam logic [3:0] EVT_FAIL            = 4'd2;
    localparam logic [3:0] EVT_ARM             = 4'd3;
    localparam logic [3:0] EVT_DISARM          = 4'd4;
    localparam logic [3:0] EVT_IMPACT          = 4'd5;
    localparam logic [3:0] EVT_POSTCRASH       = 4'd6;
    localparam logic [3:0] EVT_RECORD_COMPLETE = 4'd7;
    localparam logic [3:0] EVT_FAULT           = 4'd8;
    localparam logic [3:0] EVT_RECOVERY        = 4'd9;

    localparam logic [15:0] POSTCRASH_RESET = 16'd5000;
    localparam logic [15:0] TIM_MAX         = 16'hFFFF;

    typedef struct packed {
        mode_t       src;
        mode_t       dst;
        logic [3:0]  evt;
        logic [31:0] stamp;
    } log_entry_t;

    typedef struct packed {
        logic       en;
        log_entry_t entry;
    } log_wr_t;

    typedef struct packed {
        logic  ok;
        mode_t dst;
    } step_t;

    function automatic step_t next_mode(mode_t m, logic [3:0] e);
        step_t r;
        r.ok  = 1'b0;
        r.dst = MODE_INIT;
        if (e == EVT_FAULT && m != MODE_FAULT)
        begin
            r.ok  = 1'b1;
            r.dst = MODE_FAULT;
        end
        else
        begin
            case (m)
                MODE_INIT:
                begin
                    if (e == EVT_INIT_COMPLETE)
                    begin
                        r.ok  = 1'b1;
                        r.dst = MODE_SELF_TEST;
                    end
                end
                MODE_SELF_TEST:
                begin
                    if (e == EVT_PASS)
                    begin
                        r.ok  = 1'b1;
                        r.dst = MODE_IDLE;
                    end
                    else if (e == EVT_FAIL)
                    begin
                        r.ok  = 1'b1;
                        r.dst = MODE_FAULT;
                    end
                end
                MODE_IDLE:
                begin
                    if (e == EVT_ARM)
                    begin
                        r.ok  = 1'b1;
                        r.dst = MODE_ARMED;
                    end
                end
                MODE_ARMED:
                begin
                    if (e == EVT_DISARM)
                    begin
                        r.ok  = 1'b1;
                        r.dst = MODE_IDLE;
                    end
                    else if (e == EVT_IMPACT)
                    begin
                        r.ok  = 1'b1;
                        r.dst = MODE_RECORDING;
                    end
                end
                MODE_RECORDING:
                begin
                    if (e == EVT_POSTCRASH)
                    begin
                        r.ok  = 1'b1;
                        r.dst = MODE_POST_CRASH;
                    end
                    else if (e == EVT_RECORD_COMPLETE)
                    begin
                        r.ok  = 1'b1;
                        r.dst = MODE_IDLE;
                    end
                end
                MODE_POST_CRASH:
                begin
                    if (e == EVT_RECORD_COMPLETE)
                    begin
                        r.ok  = 1'b1;
                        r.dst = MODE_IDLE;
                    end
                end
                MODE_FAULT:
                begin
                    if (e == EVT_RECOVERY)
                    begin
                        r.ok  = 1'b1;
                        r.dst = MODE_INIT;
                    end
                end
                default:
                begin
                    r.ok = 1'b0;
                end
            endcase
        end
        return r;
    endfunction

endpackage

/* rtl/crmf_in_if.sv */
interface crmf_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [3:0] event_code;
    logic [3:0] log_index;

    modport source (output valid, output action, output event_code, output log_index,
                    input ready);
    modport sink (input valid, input action, input event_code, input log_index,
                  output ready);
endinterface

/* rtl/crmf_out_if.sv */
interface crmf_out_if #(
    parameter int FILL_W = 5
);
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [2:0]        mode;
    logic [2:0]        previous_mode;
    logic              moved;
    logic [FILL_W-1:0] entries_logged;
    logic [2:0]        entry_from;
    logic [2:0]        entry_to;
    logic [3:0]        entry_event;
    logic [31:0]       entry_time;

    modport source (output valid, output status, output mode, output previous_mode,
                    output moved, output entries_logged, output entry_from,
                    output entry_to, output entry_event, output entry_time,
                    input ready);
    modport sink (input valid, input status, input mode, input previous_mode,
                  input moved, input entries_logged, input entry_from,
                  input entry_to, input entry_event, input entry_time,
                  output ready);
endinterface

/* rtl/crmf_log.sv */
module crmf_log
    import crmf_pkg::*;
#(
    parameter int LOG_DEPTH = 16,
    localparam int HW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1,
    localparam int FW = $clog2(LOG_DEPTH + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  log_wr_t       wr,
    input  logic          rd_en,
    input  logic [HW-1:0] rd_addr,
    output logic [FW-1:0] fill,
    output log_entry_t    rd_entry
);

    log_entry_t    mem [LOG_DEPTH];
    log_entry_t    rd_reg;
    logic [HW-1:0] head_reg;
    logic [HW-1:0] head_next;
    logic [FW-1:0] fill_reg;
    logic [FW-1:0] fill_next;

    always_comb
    begin
        head_next = head_reg;
        fill_next = fill_reg;
        if (wr.en)
        begin
            head_next = (head_reg == HW'(LOG_DEPTH - 1)) ? '0 : head_reg + 1'b1;
            if (fill_reg != FW'(LOG_DEPTH))
            begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[head_reg] <= wr.entry;
        end
        if (rd_en)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    assign fill     = fill_reg;
    assign rd_entry = rd_reg;

endmodule

/* rtl/crash_recorder_mode_fsm.sv */
// Crash recorder mode controller. Takes one item per clock on req (event, 1 ms tick or
// log read) and returns exactly one result on rsp, registered at the edge of the transfer. The
// result register and req.ready = !rsp.valid || rsp.ready give one item per clock
// whenever rsp takes results; a stalled result holds req.ready low until it transfers.
// Mode, time in mode, the millisecond clock and the ring log head and
// fill all update at the edge that takes the item; a log read is a registered read of
// the ring memory in that same edge. Read of a slot at or past the fill count returns
// status 2 with zero entry fields. Write postcrash_duration_ms only while idle.
module crash_recorder_mode_fsm
    import crmf_pkg::*;
#(
    parameter int LOG_DEPTH = 16,
    localparam int HW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1,
    localparam int FW = $clog2(LOG_DEPTH + 1),
    localparam int IW = (HW > 4) ? HW : 4,
    localparam int CW = (IW > FW) ? IW : FW
)
(
    input  logic        clk,
    input  logic        rst_n,
    crmf_in_if.sink     req,
    crmf_out_if.source  rsp,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    mode_t         mode_reg;
    mode_t         mode_next;
    mode_t         last_reg;
    mode_t         last_next;
    logic [15:0]   tim_reg;
    logic [15:0]   tim_next;
    logic [15:0]   tim_inc;
    logic [31:0]   clk_reg;
    logic [31:0]   clk_next;
    logic [15:0]   dur_reg;

    logic          out_valid_reg;
    logic [1:0]    status_reg;
    logic [1:0]    status_next;
    logic          moved_reg;
    logic          rd_sel_reg;
    logic          rd_hit;
    log_entry_t    went_reg;

    logic          acc;
    logic          auto_fire;
    step_t         evt_step;
    step_t         tick_step;
    log_wr_t       wr;
    logic          rd_en;
    logic [IW-1:0] idx_ext;
    logic [FW-1:0] fill;
    log_entry_t    rd_entry;
    log_entry_t    out_entry;

    assign req.ready = !out_valid_reg || rsp.ready;
    assign acc       = req.valid && req.ready;

    assign idx_ext   = IW'(req.log_index);
    assign rd_hit    = CW'(req.log_index) < CW'(fill);
    assign tim_inc   = (tim_reg == TIM_MAX) ? tim_reg : tim_reg + 16'd1;
    assign auto_fire = (mode_reg == MODE_POST_CRASH) && (tim_inc > dur_reg);
    assign evt_step  = next_mode(mode_reg, req.event_code);
    assign tick_step = next_mode(mode_reg, EVT_RECORD_COMPLETE);

    always_comb
    begin
        mode_next   = mode_reg;
        last_next   = last_reg;
        tim_next    = tim_reg;
        clk_next    = clk_reg;
        status_next = ST_OK;
        rd_en       = 1'b0;
        wr.en       = 1'b0;
        wr.entry    = '{src: mode_reg, dst: mode_reg, evt: req.event_code, stamp: clk_reg};
        if (acc)
        begin
            case (req.action)
                ACT_EVENT:
                begin
                    if (evt_step.ok)
                    begin
                        wr.en          = 1'b1;
                        wr.entry.dst   = evt_step.dst;
                    end
                    else
                    begin
                        status_next = ST_REJECT;
                    end
                end
                ACT_TICK:
                begin
                    clk_next = clk_reg + 32'd1;
                    tim_next = tim_inc;
                    if (auto_fire)
                    begin
                        wr.en          = 1'b1;
                        wr.entry.dst   = tick_step.dst;
                        wr.entry.evt   = EVT_RECORD_COMPLETE;
                        wr.entry.stamp = clk_reg + 32'd1;
                    end
                end
                ACT_READ:
                begin
                    if (rd_hit)
                    begin
                        rd_en = 1'b1;
                    end
                    else
                    begin
                        status_next = ST_EMPTY;
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
            if (wr.en)
            begin
                mode_next = wr.entry.dst;
                last_next = mode_reg;
                tim_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_INIT;
            last_reg      <= MODE_INIT;
            tim_reg       <= '0;
            clk_reg       <= '0;
            dur_reg       <= POSTCRASH_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next;
            last_reg <= last_next;
            tim_reg  <= tim_next;
            clk_reg  <= clk_next;
            if (cfg_wr_en)
            begin
                dur_reg <= cfg_wr_data;
            end
            if (acc)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            status_reg <= status_next;
            moved_reg  <= wr.en;
            rd_sel_reg <= rd_en;
            went_reg   <= wr.entry;
        end
    end

    crmf_log #(
        .LOG_DEPTH (LOG_DEPTH)
    ) u_log (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (wr),
        .rd_en    (rd_en),
        .rd_addr  (idx_ext[HW-1:0]),
        .fill     (fill),
        .rd_entry (rd_entry)
    );

    always_comb
    begin
        if (rd_sel_reg)
        begin
            out_entry = rd_entry;
        end
        else if (moved_reg)
        begin
            out_entry = went_reg;
        end
        else
        begin
            out_entry = '0;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = status_reg;
    assign rsp.mode           = mode_reg;
    assign rsp.previous_mode  = last_reg;
    assign rsp.moved          = moved_reg;
    assign rsp.entries_logged = fill;
    assign rsp.entry_from     = out_entry.src;
    assign rsp.entry_to       = out_entry.dst;
    assign rsp.entry_event    = out_entry.evt;
    assign rsp.entry_time     = out_entry.stamp;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(fill) <= CW'(LOG_DEPTH))
        else $error("log fill count above depth");

    a_move_clears_time: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |=> (tim_reg == '0) && (last_reg == $past(mode_reg)) && moved_reg)
        else $error("transition did not clear time in mode or record previous mode");

    a_auto_complete: assert property (@(posedge clk) disable iff (!rst_n)
        acc && (req.action == ACT_TICK) && auto_fire |=> (mode_reg == MODE_IDLE))
        else $error("post crash timeout did not return to idle");

    a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !rsp.ready |=> $stable(mode_reg) && $stable(clk_reg)
                                        && $stable(fill))
        else $error("state changed while result stalled");

endmodule

/* tb/crash_recorder_mode_fsm_test.sv */
`timescale 1ns / 100ps

module crash_recorder_mode_fsm_test;
    import crmf_pkg::*;

    localparam int         RING_DEPTH = 16;
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam logic [3:0] EVT_BOGUS  = 4'd15;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  mode;
        logic [2:0]  prev;
        logic        moved;
        logic [4:0]  fill;
        logic [2:0]  efrom;
        logic [2:0]  eto;
        logic [3:0]  eevt;
        logic [31:0] etime;
    } outcome_t;

    typedef struct packed {
        logic [1:0] act;
        logic [3:0] evt;
        logic [3:0] idx;
        logic       pinned;
        outcome_t   want;
    } plan_row_t;

    localparam outcome_t NO_PIN = '0;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic [15:0] cfg_wr_data;

    crmf_in_if  req_if ();
    crmf_out_if rsp_if ();

    crash_recorder_mode_fsm dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_if),
        .rsp         (rsp_if),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // recorder state as predicted
    mode_t       cur_mode  = MODE_INIT;
    mode_t       last_mode = MODE_INIT;
    logic [15:0] dwell     = '0;
    logic [15:0] post_ms   = POSTCRASH_RESET;
    logic [31:0] ms_clock  = '0;
    logic [2:0]  ring_from  [RING_DEPTH];
    logic [2:0]  ring_to    [RING_DEPTH];
    logic [3:0]  ring_evt   [RING_DEPTH];
    logic [31:0] ring_stamp [RING_DEPTH];
    logic [3:0]  ring_head = '0;
    logic [4:0]  ring_fill = '0;

    outcome_t results_q [$];
    int       errors = 0;
    int       send_idle_pct = 0;
    int       stall_pct = 0;
    logic     typed_on;
    outcome_t typed_result;

    int          idle_mix  [4] = '{0, 88, 0, 38};
    int          stall_mix [4] = '{0, 0, 88, 38};
    logic [15:0] dur_mix   [4] = '{16'd5, 16'd0, 16'd30, 16'd1};
    logic [3:0]  lift_path [6] = '{EVT_RECOVERY, EVT_INIT_COMPLETE, EVT_PASS, EVT_ARM,
                                   EVT_IMPACT, EVT_POSTCRASH};

    plan_row_t plan [25] = '{
        '{ACT_READ, 4'd0, 4'd0, 1'b1,
          '{ST_EMPTY, MODE_INIT, MODE_INIT, 1'b0, 5'd0, 3'd0, 3'd0, 4'd0, 32'd0}},
        '{ACT_READ, 4'd0, 4'd15, 1'b1,
          '{ST_EMPTY, MODE_INIT, MODE_INIT, 1'b0, 5'd0, 3'd0, 3'd0, 4'd0, 32'd0}},
        '{ACT_UNUSED, EVT_BOGUS, 4'd15, 1'b1,
          '{ST_OK, MODE_INIT, MODE_INIT, 1'b0, 5'd0, 3'd0, 3'd0, 4'd0, 32'd0}},
        '{ACT_EVENT, EVT_BOGUS, 4'd0, 1'b1,
          '{ST_REJECT, MODE_INIT, MODE_INIT, 1'b0, 5'd0, 3'd0, 3'd0, 4'd0, 32'd0}},
        '{ACT_EVENT, EVT_PASS, 4'd0, 1'b1,
          '{ST_REJECT, MODE_INIT, MODE_INIT, 1'b0, 5'd0, 3'd0, 3'd0, 4'd0, 32'd0}},
        '{ACT_TICK, 4'd0, 4'd0, 1'b1,
          '{ST_OK, MODE_INIT, MODE_INIT, 1'b0, 5'd0, 3'd0, 3'd0, 4'd0, 32'd0}},
        '{ACT_EVENT, EVT_INIT_COMPLETE, 4'd0, 1'b0, NO_PIN},
        '{ACT_EVENT, EVT_FAIL, 4'd0, 1'b0, NO_PIN},
        '{ACT_EVENT, EVT_FAULT, 4'd0, 1'b0, NO_PIN},
        '{ACT_EVENT, EVT_RECOVERY, 4'd0, 1'b0, NO_PIN},
        '{ACT_EVENT, EVT_INIT_COMPLETE, 4'd0, 1'b0, NO_PIN},
        '{ACT_EVENT, EVT_PASS, 4'd0, 1'b0, NO_PIN},
        '{ACT_EVENT, EVT_ARM, 4'd0, 1'b0, NO_PIN},
        '{ACT_EVENT, EVT_DISARM, 4'd0, 1'b0, NO_PIN},
        '{ACT_EVENT, EVT_ARM, 4'd0, 1'b0, NO_PIN},
        '{ACT_EVENT, EVT_IMPACT, 4'd0, 1'b0, NO_PIN},
        '{ACT_EVENT, EVT_RECORD_COMPLETE, 4'd0, 1'b0, NO_PIN},
        '{ACT_EVENT, EVT_ARM, 4'd0, 1'b0, NO_PIN},
        '{ACT_EVENT, EVT_IMPACT, 4'd0, 1'b0, NO_PIN},
        '{ACT_EVENT, EVT_POSTCRASH, 4'd0, 1'b0, NO_PIN},
        '{ACT_TICK, 4'd0, 4'd0, 1'b0, NO_PIN},
        '{ACT_EVENT, EVT_FAULT, 4'd0, 1'b0, NO_PIN},
        '{ACT_READ, 4'd0, 4'd0, 1'b0, NO_PIN},
        '{ACT_READ, 4'd0, 4'd14, 1'b0, NO_PIN},
        '{ACT_READ, 4'd0, 4'd15, 1'b0, NO_PIN}
    };

    function automatic logic route(input mode_t m, input logic [3:0] e, output mode_t dst);
        dst = m;
        if (e == EVT_FAULT && m != MODE_FAULT)
            dst = MODE_FAULT;
        else
        begin
            case (m)
                MODE_INIT:
                    if (e == EVT_INIT_COMPLETE) dst = MODE_SELF_TEST;
                MODE_SELF_TEST:
                begin
                    if (e == EVT_PASS) dst = MODE_IDLE;
                    else if (e == EVT_FAIL) dst = MODE_FAULT;
                end
                MODE_IDLE:
                    if (e == EVT_ARM) dst = MODE_ARMED;
                MODE_ARMED:
                begin
                    if (e == EVT_DISARM) dst = MODE_IDLE;
                    else if (e == EVT_IMPACT) dst = MODE_RECORDING;
                end
                MODE_RECORDING:
                begin
                    if (e == EVT_POSTCRASH) dst = MODE_POST_CRASH;
                    else if (e == EVT_RECORD_COMPLETE) dst = MODE_IDLE;
                end
                MODE_POST_CRASH:
                    if (e == EVT_RECORD_COMPLETE) dst = MODE_IDLE;
                MODE_FAULT:
                    if (e == EVT_RECOVERY) dst = MODE_INIT;
                default:
                    dst = m;
            endcase
        end
        return dst != m;
    endfunction

    function automatic logic [3:0] lawful_event(input mode_t m);
        logic [3:0] e;
        case (m)
            MODE_INIT:       e = EVT_INIT_COMPLETE;
            MODE_SELF_TEST:  e = ($urandom_range(3) == 0) ? EVT_FAIL : EVT_PASS;
            MODE_IDLE:       e = EVT_ARM;
            MODE_ARMED:      e = ($urandom_range(2) == 0) ? EVT_DISARM : EVT_IMPACT;
            MODE_RECORDING:  e = ($urandom_range(2) == 0) ? EVT_RECORD_COMPLETE : EVT_POSTCRASH;
            MODE_POST_CRASH: e = EVT_RECORD_COMPLETE;
            default:         e = EVT_RECOVERY;
        endcase
        if (m != MODE_FAULT && $urandom_range(11) == 0)
            e = EVT_FAULT;
        return e;
    endfunction

    function automatic string show(input outcome_t o);
        return $sformatf("st=%0d mode=%0d prev=%0d moved=%0d fill=%0d from=%0d to=%0d evt=%0d time=%0d",
                         o.status, o.mode, o.prev, o.moved, o.fill, o.efrom, o.eto, o.eevt,
                         o.etime);
    endfunction

    task automatic log_move(input mode_t dst, input logic [3:0] evt, inout outcome_t r);
        ring_from[ring_head]  = cur_mode;
        ring_to[ring_head]    = dst;
        ring_evt[ring_head]   = evt;
        ring_stamp[ring_head] = ms_clock;
        r.moved = 1'b1;
        r.efrom = cur_mode;
        r.eto   = dst;
        r.eevt  = evt;
        r.etime = ms_clock;
        ring_head = ring_head + 4'd1;
        if (ring_fill != 5'(RING_DEPTH))
            ring_fill = ring_fill + 5'd1;
        last_mode = cur_mode;
        cur_mode  = dst;
        dwell     = '0;
    endtask

    task automatic advance(input logic [1:0] act, input logic [3:0] evt, input logic [3:0] idx,
                           output outcome_t r);
        mode_t dst;
        r = '0;
        case (act)
            ACT_EVENT:
            begin
                if (route(cur_mode, evt, dst))
                    log_move(dst, evt, r);
                else
                    r.status = ST_REJECT;
            end
            ACT_TICK:
            begin
                ms_clock = ms_clock + 32'd1;
                if (dwell != TIM_MAX)
                    dwell = dwell + 16'd1;
                if (cur_mode == MODE_POST_CRASH && dwell > post_ms)
                    log_move(MODE_IDLE, EVT_RECORD_COMPLETE, r);
            end
            ACT_READ:
            begin
                if (idx < ring_fill)
                begin
                    r.efrom = ring_from[idx];
                    r.eto   = ring_to[idx];
                    r.eevt  = ring_evt[idx];
                    r.etime = ring_stamp[idx];
                end
                else
                    r.status = ST_EMPTY;
            end
            default:
                r.status = ST_OK;
        endcase
        r.mode = cur_mode;
        r.prev = last_mode;
        r.fill = ring_fill;
    endtask

    // check the oldest expectation first, then record what this edge accepts
    always @(posedge clk)
    begin : watch
        outcome_t got;
        outcome_t want;
        if (rsp_if.valid && rsp_if.ready)
        begin
            got = '{rsp_if.status, rsp_if.mode, rsp_if.previous_mode, rsp_if.moved,
                    rsp_if.entries_logged, rsp_if.entry_from, rsp_if.entry_to,
                    rsp_if.entry_event, rsp_if.entry_time};
            if (results_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected result %s", $time, show(got));
            end
            else
            begin
                want = results_q.pop_front();
                if (got !== want)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: mismatch\n  expected %s\n  actual   %s", $time,
                                 show(want), show(got));
                end
            end
        end
        if (req_if.valid && req_if.ready)
        begin
            advance(req_if.action, req_if.event_code, req_if.log_index, want);
            if (typed_on)
                want = typed_result;
            results_q.push_back(want);
        end
    end

    initial
    begin
        rsp_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // call at a falling edge; holds valid until the transfer
    task automatic offer(input logic [1:0] act, input logic [3:0] evt, input logic [3:0] idx,
                         input logic on, input outcome_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(negedge clk);
        end
        req_if.valid      <= 1'b1;
        req_if.action     <= act;
        req_if.event_code <= evt;
        req_if.log_index  <= idx;
        typed_on          <= on;
        typed_result      <= want;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
    endtask

    task automatic settle();
        @(negedge clk);
        req_if.valid <= 1'b0;
        while (results_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_duration(input logic [15:0] value);
        settle();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        post_ms = value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_item();
        int roll;
        logic [1:0] act;
        logic [3:0] evt;
        logic [3:0] idx;
        @(negedge clk);
        roll = $urandom_range(99);
        act  = ACT_EVENT;
        evt  = 4'($urandom_range(15));
        idx  = 4'($urandom_range(15));
        if (cur_mode == MODE_POST_CRASH && roll < 60)
            act = ACT_TICK;
        else if (roll < 45)
            evt = lawful_event(cur_mode);
        else if (roll < 55)
            act = ACT_EVENT;
        else if (roll < 83)
            act = ACT_TICK;
        else if (roll < 98)
            act = ACT_READ;
        else
            act = ACT_UNUSED;
        offer(act, evt, idx, 1'b0, NO_PIN);
    endtask

    initial
    begin
        #8_000_000;
        $display("crash_recorder_mode_fsm_test: FAIL");
        $finish;
    end

    initial
    begin
        int k;
        int phase;
        rst_n             = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_wr_data       = '0;
        req_if.valid      = 1'b0;
        req_if.action     = ACT_EVENT;
        req_if.event_code = EVT_INIT_COMPLETE;
        req_if.log_index  = '0;
        typed_on          = 1'b0;
        typed_result      = NO_PIN;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed walk with a zero post-crash hold
        write_duration(16'd0);
        for (k = 0; k < 25; k++)
        begin
            @(negedge clk);
            offer(plan[k].act, plan[k].evt, plan[k].idx, plan[k].pinned, plan[k].want);
        end

        // near-maximum hold: ticks stay in post-crash
        write_duration(16'd65534);
        for (k = 0; k < 6; k++)
        begin
            @(negedge clk);
            offer(ACT_EVENT, lift_path[k], 4'd0, 1'b0, NO_PIN);
        end
        repeat (40)
        begin
            @(negedge clk);
            offer(ACT_TICK, 4'd0, 4'd0, 1'b0, NO_PIN);
        end

        for (phase = 0; phase < 4; phase++)
        begin
            write_duration(phase == 3 ? 16'($urandom_range(1, 40)) : dur_mix[phase]);
            send_idle_pct = idle_mix[phase];
            stall_pct     = stall_mix[phase];
            repeat (350)
            begin
                if ($urandom_range(59) == 0)
                    settle();
                random_item();
            end
        end

        settle();
        repeat (4) @(negedge clk);
        if (errors == 0 && results_q.size() == 0)
            $display("crash_recorder_mode_fsm_test: PASS");
        else
            $display("crash_recorder_mode_fsm_test: FAIL");
        $finish;
    end
endmodule

/* crash_recorder_mode_fsm.f */
rtl/crmf_pkg.sv
rtl/crmf_in_if.sv
rtl/crmf_out_if.sv
rtl/crmf_log.sv
rtl/crash_recorder_mode_fsm.sv
tb/crash_recorder_mode_fsm_test.sv
